[design/dqvd_pkg.sv]
package dqvd_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]              req_type;
        logic signed [VALUE_WIDTH-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] out_value;
        logic [STATUS_W-1:0]           status;
        logic [CNT_W-1:0]              entry_count;
    } rsp_t;

    // Circular slot of the entry at a given offset from the front.
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                 input logic [PTR_W-1:0] offset);
        logic [PTR_W:0] sum;
        sum = {1'b0, front} + {1'b0, offset};
        if (sum >= (PTR_W+1)'(DEPTH))
            sum = sum - (PTR_W+1)'(DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    // Slot just ahead of the front, with wrap.
    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] front);
        logic [PTR_W-1:0] res;
        if (front == '0)
            res = PTR_W'(DEPTH - 1);
        else
            res = front - 1'b1;
        return res;
    endfunction

endpackage

[design/deque_with_value_delete_top.sv]
// Bounded double-ended queue of signed values with delete-by-value.
// Request channel (req_valid/req_ready, payload req): push front, push back,
// pop front, pop back, or delete the first entry from the front that equals
// req.item_value. Every request yields exactly one item on the response
// channel (rsp_valid/rsp_ready, payload rsp): popped value, status and the
// entry count after the request.
// Entries live in one DEPTH-entry synchronous RAM (one write port, one read
// port, registered read data); a small sequencer reads, compares and writes
// back through it. One request is in flight at a time.
// Sequence per request: a push or a rejected request goes straight to FINISH;
// a pop reads the RAM and takes the registered read data in POP_WAIT; a delete
// scans one entry per cycle in SCAN, then closes the gap one entry per cycle
// in SHIFT through the same RAM ports. The next request is taken once the
// sequencer is back in IDLE.
// req_ready is high whenever the sequencer is idle, also while a finished
// response still waits in the output register; if the next response is done
// before that one is taken, it is held until the output register frees up.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending
// response; RAM contents are not cleared and are only read once written.
module deque_with_value_delete_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  dqvd_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output dqvd_pkg::rsp_t  rsp
);

    localparam int XW = dqvd_pkg::PTR_W + 2;

    typedef enum logic [2:0] {
        IDLE,
        POP_WAIT,
        SCAN,
        SHIFT,
        FINISH
    } state_t;

    state_t                                state_reg, state_next;
    logic [dqvd_pkg::PTR_W-1:0]            front_reg, front_next;
    logic [dqvd_pkg::CNT_W-1:0]            count_reg, count_next;
    logic [dqvd_pkg::VALUE_WIDTH-1:0]      value_reg, value_next;
    logic [dqvd_pkg::PTR_W-1:0]            idx_reg, idx_next;
    dqvd_pkg::rsp_t                        res_reg, res_next;
    dqvd_pkg::rsp_t                        rsp_reg, rsp_next;
    logic                                  rsp_valid_reg, rsp_valid_next;

    // Entry RAM
    logic [dqvd_pkg::VALUE_WIDTH-1:0]      mem [dqvd_pkg::DEPTH];
    logic [dqvd_pkg::VALUE_WIDTH-1:0]      mem_rdata_reg;
    logic                                  mem_we;
    logic [dqvd_pkg::PTR_W-1:0]            mem_waddr;
    logic [dqvd_pkg::VALUE_WIDTH-1:0]      mem_wdata;
    logic [dqvd_pkg::PTR_W-1:0]            mem_raddr;

    logic                                  is_full;
    logic                                  is_empty;
    logic [dqvd_pkg::CNT_W-1:0]            count_inc;
    logic [dqvd_pkg::CNT_W-1:0]            count_dec;
    logic [dqvd_pkg::PTR_W-1:0]            idx_inc;
    logic [XW-1:0]                         idx_x1;
    logic [XW-1:0]                         idx_x2;
    logic [XW-1:0]                         count_x;

    assign is_full   = (count_reg == dqvd_pkg::CNT_W'(dqvd_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_x1    = XW'(idx_reg) + XW'(1);
    assign idx_x2    = XW'(idx_reg) + XW'(2);
    assign count_x   = XW'(count_reg);

    assign req_ready = (state_reg == IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = front_reg;
        mem_wdata      = req.item_value;
        mem_raddr      = front_reg;

        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    value_next           = req.item_value;
                    idx_next             = '0;
                    res_next.out_value   = '0;
                    res_next.status      = dqvd_pkg::ST_DONE;
                    res_next.entry_count = count_reg;
                    state_next           = FINISH;
                    case (req.req_type)
                        dqvd_pkg::REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                                res_next.status = dqvd_pkg::ST_FULL;
                            else
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = dqvd_pkg::slot_dec(front_reg);
                                front_next           = dqvd_pkg::slot_dec(front_reg);
                                count_next           = count_inc;
                                res_next.entry_count = count_inc;
                            end
                        end
                        dqvd_pkg::REQ_PUSH_BACK:
                        begin
                            if (is_full)
                                res_next.status = dqvd_pkg::ST_FULL;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = dqvd_pkg::slot_of(front_reg,
                                                count_reg[dqvd_pkg::PTR_W-1:0]);
                                count_next           = count_inc;
                                res_next.entry_count = count_inc;
                            end
                        end
                        dqvd_pkg::REQ_POP_FRONT:
                        begin
                            if (is_empty)
                                res_next.status = dqvd_pkg::ST_EMPTY;
                            else
                            begin
                                mem_raddr            = front_reg;
                                front_next           = dqvd_pkg::slot_of(front_reg,
                                                           dqvd_pkg::PTR_W'(1));
                                count_next           = count_dec;
                                res_next.entry_count = count_dec;
                                state_next           = POP_WAIT;
                            end
                        end
                        dqvd_pkg::REQ_POP_BACK:
                        begin
                            if (is_empty)
                                res_next.status = dqvd_pkg::ST_EMPTY;
                            else
                            begin
                                mem_raddr = dqvd_pkg::slot_of(front_reg,
                                                count_dec[dqvd_pkg::PTR_W-1:0]);
                                count_next           = count_dec;
                                res_next.entry_count = count_dec;
                                state_next           = POP_WAIT;
                            end
                        end
                        dqvd_pkg::REQ_DELETE:
                        begin
                            if (is_empty)
                                res_next.status = dqvd_pkg::ST_EMPTY;
                            else
                            begin
                                mem_raddr  = front_reg;
                                state_next = SCAN;
                            end
                        end
                        default:
                        begin
                            // unused codes: done, nothing changes
                        end
                    endcase
                end
            end

            POP_WAIT:
            begin
                res_next.out_value = mem_rdata_reg;
                state_next         = FINISH;
            end

            SCAN:
            begin
                // read data holds entry idx; fetch idx+1 meanwhile
                mem_raddr = dqvd_pkg::slot_of(front_reg, idx_inc);
                if (mem_rdata_reg == value_reg)
                begin
                    if (idx_x1 >= count_x)
                    begin
                        // match on the back entry: no gap to close
                        count_next           = count_dec;
                        res_next.entry_count = count_dec;
                        state_next           = FINISH;
                    end
                    else
                        state_next = SHIFT;
                end
                else if (idx_x1 >= count_x)
                begin
                    res_next.status = dqvd_pkg::ST_NOT_FOUND;
                    state_next      = FINISH;
                end
                else
                    idx_next = idx_inc;
            end

            SHIFT:
            begin
                // read data holds entry idx+1; move it down to idx
                mem_we    = 1'b1;
                mem_waddr = dqvd_pkg::slot_of(front_reg, idx_reg);
                mem_wdata = mem_rdata_reg;
                mem_raddr = dqvd_pkg::slot_of(front_reg, idx_reg + dqvd_pkg::PTR_W'(2));
                if (idx_x2 < count_x)
                    idx_next = idx_inc;
                else
                begin
                    count_next           = count_dec;
                    res_next.entry_count = count_dec;
                    state_next           = FINISH;
                end
            end

            FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            value_reg     <= '0;
            idx_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            value_reg     <= value_next;
            idx_reg       <= idx_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    // Occupancy never exceeds capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dqvd_pkg::CNT_W'(dqvd_pkg::DEPTH))
        else $error("entry count above capacity");

    // A full status is only reported with a full queue.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == dqvd_pkg::ST_FULL
        |-> rsp_reg.entry_count == dqvd_pkg::CNT_W'(dqvd_pkg::DEPTH))
        else $error("full status with free space");

    // An empty status is only reported with an empty queue.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == dqvd_pkg::ST_EMPTY
        |-> rsp_reg.entry_count == '0)
        else $error("empty status with entries held");

    // Failed requests never return a value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != dqvd_pkg::ST_DONE
        |-> rsp_reg.out_value == '0)
        else $error("value returned on failed request");

    // One request at a time: acceptance closes the request channel.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted while busy");

    // The count never changes while the sequencer is in FINISH.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) != FINISH)
        else $error("count changed while finishing");

endmodule
